### rtl/tclc_pkg.sv
// Package: widths, fixed-point constants and coefficient tables of the lux calculator.
`timescale 1ns / 1ps
`default_nettype none
package tclc_pkg;

	localparam int CHANNEL_SCALE_BITS  = 10;
	localparam int RATIO_FRACTION_BITS = 9;
	localparam int LUX_FRACTION_BITS   = 14;

	// register indexes of the configuration port
	localparam logic [1:0] REG_GAIN_HIGH   = 2'd0;
	localparam logic [1:0] REG_INTEG_SEL   = 2'd1;
	localparam logic [1:0] REG_PACKAGE_SEL = 2'd2;

	// integration time codes
	localparam logic [1:0] INTEG_13MS  = 2'd0;
	localparam logic [1:0] INTEG_101MS = 2'd1;

	localparam int COUNT_W = 16;
	// largest scale is below 32 * 16 in integer part
	localparam int SCALE_W = CHANNEL_SCALE_BITS + 9;
	localparam int CH_W    = COUNT_W + SCALE_W - CHANNEL_SCALE_BITS;

	localparam int SCALE_13MS_INT  = ((((322 << CHANNEL_SCALE_BITS) * 2) / 11) + 1) >> 1;
	localparam int SCALE_101MS_INT = ((((322 << CHANNEL_SCALE_BITS) * 2) / 81) + 1) >> 1;
	localparam logic [SCALE_W-1:0] SCALE_13MS  = SCALE_W'(SCALE_13MS_INT);
	localparam logic [SCALE_W-1:0] SCALE_101MS = SCALE_W'(SCALE_101MS_INT);
	localparam logic [SCALE_W-1:0] SCALE_ONE   = SCALE_W'(1 << CHANNEL_SCALE_BITS);

	// quotient bits kept: every knee times two stays below 2^QUO_W
	localparam int QUO_W      = RATIO_FRACTION_BITS + 2;
	localparam int DIV_STEPS  = 3;
	localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

	localparam int SEGMENTS  = 7;
	localparam int COEF_BITS = 14;
	localparam int COEF_UP   = (LUX_FRACTION_BITS > COEF_BITS) ?
		(LUX_FRACTION_BITS - COEF_BITS) : 0;
	localparam int COEF_DN   = (LUX_FRACTION_BITS < COEF_BITS) ?
		(COEF_BITS - LUX_FRACTION_BITS) : 0;
	localparam int COEF_W    = 10 + COEF_UP;
	localparam int PROD_W    = CH_W + COEF_W;
	localparam int RND_W     = PROD_W + 1 - LUX_FRACTION_BITS;

	localparam int RAW_W = 20;
	localparam int CAL_W = 21;
	localparam logic [RAW_W-1:0] RAW_MAX = '1;
	localparam logic [CAL_W-1:0] CAL_MAX = '1;
	localparam logic [16:0]      CAL_GAIN   = 17'd75039;
	localparam logic [21:0]      CAL_OFFSET = 22'd3019244;
	localparam int               CAL_FLOOR  = 46;
	localparam int               CAL_PROD_W = RAW_W + 17;
	localparam int               CAL_SUM_W  = CAL_PROD_W + 1;

	// pipeline depth from accepted command to result strobe
	localparam int LATENCY = DIV_STAGES + 6;

	// knee limit on the unrounded quotient: ratio <= k exactly when quotient <= 2k
	function automatic logic [QUO_W:0] knee_limit(input logic pkg, input int seg);
		int milli;
		begin
			milli = 1300;
			case (seg)
				0: milli = pkg ? 130 : 125;
				1: milli = pkg ? 260 : 250;
				2: milli = pkg ? 390 : 375;
				3: milli = pkg ? 520 : 500;
				4: milli = pkg ? 650 : 610;
				5: milli = 800;
				default: milli = 1300;
			endcase
			knee_limit = (QUO_W+1)'((((milli << RATIO_FRACTION_BITS) + 500) / 1000) * 2);
		end
	endfunction

	function automatic logic [COEF_W-1:0] coef_scale(input int v);
		begin
			if (COEF_DN == 0)
				coef_scale = COEF_W'(v << COEF_UP);
			else
				coef_scale = COEF_W'((v + (1 << (COEF_DN - 1))) >> COEF_DN);
		end
	endfunction

	function automatic logic [COEF_W-1:0] coef_b(input logic pkg, input int seg);
		int v;
		begin
			v = 0;
			case (seg)
				0: v = pkg ? 'h204 : 'h1f2;
				1: v = pkg ? 'h228 : 'h214;
				2: v = pkg ? 'h253 : 'h23f;
				3: v = pkg ? 'h282 : 'h270;
				4: v = pkg ? 'h177 : 'h16f;
				5: v = pkg ? 'h101 : 'h0d2;
				default: v = pkg ? 'h037 : 'h018;
			endcase
			coef_b = coef_scale(v);
		end
	endfunction

	function automatic logic [COEF_W-1:0] coef_m(input logic pkg, input int seg);
		int v;
		begin
			v = 0;
			case (seg)
				0: v = pkg ? 'h1ad : 'h1be;
				1: v = pkg ? 'h2c1 : 'h2d1;
				2: v = pkg ? 'h363 : 'h37b;
				3: v = pkg ? 'h3df : 'h3fe;
				4: v = pkg ? 'h1dd : 'h1fc;
				5: v = pkg ? 'h127 : 'h0fb;
				default: v = pkg ? 'h02b : 'h012;
			endcase
			coef_m = coef_scale(v);
		end
	endfunction

endpackage
`default_nettype wire

### rtl/two_channel_lux_calculator.sv
// Top level: pipelined two-channel photodiode lux calculator.
//
// Usage:
//   Command channel: pulse start with broadband_count and infrared_count; the
//   pair is taken at any clock edge where start is high and busy is low. busy
//   stays low, so a new pair may be issued every cycle.
//   Result channel: raw_lux and calibrated_lux appear for one cycle with done
//   high, once the pair has passed the pipeline stages named below. Results
//   come in command order.
//   Throughput: one pair per cycle. The depth is set by the ratio divider,
//   which resolves up to three quotient bits per stage, plus the scale,
//   segment, coefficient multiply, rounding and calibration stages.
//   Configuration: cfg_write with cfg_index and cfg_data writes gain_high,
//   integration_select or package_select; write only while no result is
//   outstanding. Unknown indexes are dropped.
//   Reset: arst_n clears the configuration and valid registers to 0 and
//   empties the pipeline; no clearing pass is needed. The receiver cannot
//   stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module two_channel_lux_calculator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [tclc_pkg::COUNT_W-1:0]  broadband_count,
	input  wire logic [tclc_pkg::COUNT_W-1:0]  infrared_count,
	input  wire logic                          cfg_write,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [1:0]                    cfg_data,
	output logic                               done,
	output logic [tclc_pkg::RAW_W-1:0]         raw_lux,
	output logic [tclc_pkg::CAL_W-1:0]         calibrated_lux
);
	import tclc_pkg::*;

	logic       gain_high_q;
	logic [1:0] integ_sel_q;
	logic       package_sel_q;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_high_q   <= 1'b0;
			integ_sel_q   <= 2'd0;
			package_sel_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_GAIN_HIGH:   gain_high_q   <= cfg_data[0];
				REG_INTEG_SEL:   integ_sel_q   <= cfg_data;
				REG_PACKAGE_SEL: package_sel_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: pick scale and scale both channels
	logic [SCALE_W-1:0]         scale_base;
	logic [SCALE_W-1:0]         scale;
	logic [COUNT_W+SCALE_W-1:0] prod0, prod1;
	logic                       v_s1;
	logic [CH_W-1:0]            ch0_s1, ch1_s1;

	always_comb begin
		case (integ_sel_q)
			INTEG_13MS:  scale_base = SCALE_13MS;
			INTEG_101MS: scale_base = SCALE_101MS;
			default:     scale_base = SCALE_ONE;
		endcase
		scale = gain_high_q ? scale_base : (scale_base << 4);
		prod0 = (COUNT_W+SCALE_W)'(broadband_count) * (COUNT_W+SCALE_W)'(scale);
		prod1 = (COUNT_W+SCALE_W)'(infrared_count) * (COUNT_W+SCALE_W)'(scale);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		ch0_s1 <= prod0[CHANNEL_SCALE_BITS +: CH_W];
		ch1_s1 <= prod1[CHANNEL_SCALE_BITS +: CH_W];
	end

	// stage 2: restoring divider, up to three quotient bits per stage
	logic             dv_v_s2   [DIV_STAGES];
	logic [CH_W-1:0]  dv_rem_s2 [DIV_STAGES];
	logic [QUO_W-1:0] dv_q_s2   [DIV_STAGES];
	logic [CH_W-1:0]  dv_ch0_s2 [DIV_STAGES];
	logic [CH_W-1:0]  dv_ch1_s2 [DIV_STAGES];
	logic             dv_ovf_s2 [DIV_STAGES];
	logic             dv_zero_s2[DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic             in_v;
		logic [CH_W-1:0]  in_rem;
		logic [QUO_W-1:0] in_q;
		logic [CH_W-1:0]  in_ch0, in_ch1;
		logic             in_ovf, in_zero;
		logic [CH_W-1:0]  rem_n;
		logic [QUO_W-1:0] q_n;
		logic [CH_W:0]    trial;

		if (k == 0) begin : g_first
			// quotient of ch1 << (R+1) over ch0; it overflows the kept bits when ch1 >= 2*ch0
			assign in_v    = v_s1;
			assign in_rem  = ch1_s1 >> 1;
			assign in_q    = '0;
			assign in_ch0  = ch0_s1;
			assign in_ch1  = ch1_s1;
			assign in_ovf  = {1'b0, ch1_s1} >= {ch0_s1, 1'b0};
			assign in_zero = (ch0_s1 == '0);
		end else begin : g_next
			assign in_v    = dv_v_s2[k-1];
			assign in_rem  = dv_rem_s2[k-1];
			assign in_q    = dv_q_s2[k-1];
			assign in_ch0  = dv_ch0_s2[k-1];
			assign in_ch1  = dv_ch1_s2[k-1];
			assign in_ovf  = dv_ovf_s2[k-1];
			assign in_zero = dv_zero_s2[k-1];
		end

		// shift in the next numerator bit, subtract when it fits
		always_comb begin
			rem_n = in_rem;
			q_n   = in_q;
			trial = '0;
			for (int t = 0; t < DIV_STEPS; t++) begin
				if (k * DIV_STEPS + t < QUO_W) begin
					trial = {rem_n, ((k * DIV_STEPS + t) == 0) ? in_ch1[0] : 1'b0};
					if (trial >= {1'b0, in_ch0}) begin
						trial = trial - {1'b0, in_ch0};
						q_n   = {q_n[QUO_W-2:0], 1'b1};
					end else begin
						q_n   = {q_n[QUO_W-2:0], 1'b0};
					end
					rem_n = trial[CH_W-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s2[k] <= 1'b0;
			else         dv_v_s2[k] <= in_v;
		end

		always_ff @(posedge clk) begin
			dv_rem_s2[k]  <= rem_n;
			dv_q_s2[k]    <= q_n;
			dv_ch0_s2[k]  <= in_ch0;
			dv_ch1_s2[k]  <= in_ch1;
			dv_ovf_s2[k]  <= in_ovf;
			dv_zero_s2[k] <= in_zero;
		end
	end

	// stage 3: find the segment and fetch its coefficients
	logic              v_s3;
	logic [CH_W-1:0]   ch0_s3, ch1_s3;
	logic [COEF_W-1:0] b_s3, m_s3;
	logic [COEF_W-1:0] b_n, m_n;
	logic [QUO_W:0]    quo;
	logic              hit;

	always_comb begin
		quo = {1'b0, dv_q_s2[DIV_STAGES-1]};
		b_n = '0;
		m_n = '0;
		hit = 1'b0;
		for (int i = 0; i < SEGMENTS; i++) begin
			if (!hit && (dv_zero_s2[DIV_STAGES-1] ||
			             (!dv_ovf_s2[DIV_STAGES-1] && quo <= knee_limit(package_sel_q, i)))) begin
				hit = 1'b1;
				b_n = coef_b(package_sel_q, i);
				m_n = coef_m(package_sel_q, i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= dv_v_s2[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		ch0_s3 <= dv_ch0_s2[DIV_STAGES-1];
		ch1_s3 <= dv_ch1_s2[DIV_STAGES-1];
		b_s3   <= b_n;
		m_s3   <= m_n;
	end

	// stage 4: weight both channels
	logic              v_s4;
	logic [PROD_W-1:0] pos_s4, neg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		pos_s4 <= PROD_W'(ch0_s3) * PROD_W'(b_s3);
		neg_s4 <= PROD_W'(ch1_s3) * PROD_W'(m_s3);
	end

	// stage 5: clamp at zero, round, drop the fraction, saturate
	logic              v_s5;
	logic [RAW_W-1:0]  raw_s5;
	logic [PROD_W-1:0] diff;
	logic [RND_W-1:0]  rnd;
	logic [RAW_W-1:0]  raw_n;

	always_comb begin
		diff  = (pos_s4 > neg_s4) ? (pos_s4 - neg_s4) : '0;
		rnd   = RND_W'(({1'b0, diff} + ((PROD_W+1)'(1) << (LUX_FRACTION_BITS - 1)))
			>> LUX_FRACTION_BITS);
		raw_n = (rnd > RND_W'(RAW_MAX)) ? RAW_MAX : rnd[RAW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		raw_s5 <= raw_n;
	end

	// stage 6: calibration gain
	logic                  v_s6;
	logic [RAW_W-1:0]      raw_s6;
	logic [CAL_PROD_W-1:0] cal_prod_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		raw_s6      <= raw_s5;
		cal_prod_s6 <= CAL_PROD_W'(raw_s5) * CAL_PROD_W'(CAL_GAIN);
	end

	// output: add offset, floor, force small values to zero, saturate
	logic [CAL_SUM_W-1:0]    cal_sum;
	logic [CAL_SUM_W-17:0]   cal_int;
	logic [CAL_W-1:0]        cal_n;
	logic                    done_q;
	logic [RAW_W-1:0]        raw_lux_q;
	logic [CAL_W-1:0]        cal_lux_q;

	always_comb begin
		cal_sum = CAL_SUM_W'(cal_prod_s6) + CAL_SUM_W'(CAL_OFFSET);
		cal_int = cal_sum[CAL_SUM_W-1:16];
		if (cal_int <= (CAL_SUM_W-16)'(CAL_FLOOR))
			cal_n = '0;
		else if (cal_int > (CAL_SUM_W-16)'(CAL_MAX))
			cal_n = CAL_MAX;
		else
			cal_n = cal_int[CAL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= v_s6;
	end

	always_ff @(posedge clk) begin
		raw_lux_q <= raw_s6;
		cal_lux_q <= cal_n;
	end

	assign done           = done_q;
	assign raw_lux        = raw_lux_q;
	assign calibrated_lux = cal_lux_q;

endmodule
`default_nettype wire

### rtl/tclc_checker.sv
// Checker: port-level assertions for the lux calculator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tclc_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic                         done,
	input wire logic [tclc_pkg::RAW_W-1:0]   raw_lux,
	input wire logic [tclc_pkg::CAL_W-1:0]   calibrated_lux
);
	import tclc_pkg::*;

	// the pipeline never refuses a command
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// every accepted command yields a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after accepted command");

	// no result without a command that many cycles earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without command");

	// calibration never lowers lux, and zero raw lux gives zero calibrated lux
	a_cal_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((calibrated_lux >= CAL_W'(raw_lux)) &&
		          ((raw_lux != '0) || (calibrated_lux == '0))))
		else $error("calibrated lux inconsistent with raw lux");

endmodule

bind two_channel_lux_calculator tclc_checker u_tclc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.raw_lux        (raw_lux),
	.calibrated_lux (calibrated_lux)
);
`default_nettype wire

### tb/two_channel_lux_calculator_test.sv
// Self-checking testbench for the pipelined two-channel lux calculator.
`timescale 1ns / 1ps
`default_nettype none
module two_channel_lux_calculator_test;
	import tclc_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] bb;
		logic [COUNT_W-1:0] ir;
	} count_pair_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw;
		logic [CAL_W-1:0] cal;
	} lux_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [COUNT_W-1:0] broadband_count = '0;
	logic [COUNT_W-1:0] infrared_count = '0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [1:0] cfg_data = '0;
	logic done;
	logic [RAW_W-1:0] raw_lux;
	logic [CAL_W-1:0] calibrated_lux;

	two_channel_lux_calculator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.broadband_count(broadband_count), .infrared_count(infrared_count),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .raw_lux(raw_lux), .calibrated_lux(calibrated_lux)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the registers
	logic       gain_hi_q = 1'b0;
	logic [1:0] integ_q = 2'd0;
	logic       pkg_q = 1'b0;

	count_pair_t pending_pairs[$];
	lux_pair_t   expected_lux[$];
	int  error_count = 0;
	bit  idle_enable = 1'b1;

	function automatic lux_pair_t predict_lux(count_pair_t p);
		longint unsigned scale, ch0, ch1, ratio, b, m, pos, neg, raw, cal, knee;
		int milli[2][7];
		int cb[2][7];
		int cm[2][7];
		lux_pair_t r;
		milli = '{'{125, 250, 375, 500, 610, 800, 1300},
			'{130, 260, 390, 520, 650, 800, 1300}};
		cb = '{'{'h1f2, 'h214, 'h23f, 'h270, 'h16f, 'h0d2, 'h018},
			'{'h204, 'h228, 'h253, 'h282, 'h177, 'h101, 'h037}};
		cm = '{'{'h1be, 'h2d1, 'h37b, 'h3fe, 'h1fc, 'h0fb, 'h012},
			'{'h1ad, 'h2c1, 'h363, 'h3df, 'h1dd, 'h127, 'h02b}};
		if (integ_q == INTEG_13MS)
			scale = (((64'd322 << CHANNEL_SCALE_BITS) * 2 / 11) + 1) >> 1;
		else if (integ_q == INTEG_101MS)
			scale = (((64'd322 << CHANNEL_SCALE_BITS) * 2 / 81) + 1) >> 1;
		else
			scale = 64'd1 << CHANNEL_SCALE_BITS;
		if (!gain_hi_q)
			scale = scale << 4;
		ch0 = (p.bb * scale) >> CHANNEL_SCALE_BITS;
		ch1 = (p.ir * scale) >> CHANNEL_SCALE_BITS;
		ratio = 0;
		if (ch0 != 0)
			ratio = (ch1 << (RATIO_FRACTION_BITS + 1)) / ch0;
		ratio = (ratio + 1) >> 1;
		b = 0;
		m = 0;
		// first segment whose knee covers the ratio; past the last one both stay zero
		for (int i = 6; i >= 0; i--) begin
			knee = ((longint'(milli[pkg_q][i]) << RATIO_FRACTION_BITS) + 500) / 1000;
			if (ratio <= knee) begin
				b = longint'(cb[pkg_q][i]) << (LUX_FRACTION_BITS - 14);
				m = longint'(cm[pkg_q][i]) << (LUX_FRACTION_BITS - 14);
			end
		end
		pos = ch0 * b;
		neg = ch1 * m;
		raw = (pos > neg) ? pos - neg : 0;
		raw = (raw + (64'd1 << (LUX_FRACTION_BITS - 1))) >> LUX_FRACTION_BITS;
		if (raw > 1048575)
			raw = 1048575;
		cal = (raw * 75039 + 3019244) >> 16;
		if (cal <= 46)
			cal = 0;
		if (cal > 2097151)
			cal = 2097151;
		r.raw = raw[RAW_W-1:0];
		r.cal = cal[CAL_W-1:0];
		return r;
	endfunction

	// driver: present the next pair, idle at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_lux.push_back(predict_lux({broadband_count, infrared_count}));
				void'(pending_pairs.pop_front());
			end
			if (pending_pairs.size() != 0 &&
				!(idle_enable && $urandom_range(99) < 32)) begin
				start <= 1'b1;
				broadband_count <= pending_pairs[0].bb;
				infrared_count <= pending_pairs[0].ir;
			end else begin
				start <= 1'b0;
				broadband_count <= COUNT_W'($urandom);
				infrared_count <= COUNT_W'($urandom);
			end
		end
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		lux_pair_t want;
		if (arst_n && done) begin
			if (expected_lux.size() == 0) begin
				$display("%0t unexpected result raw %0d cal %0d", $realtime, raw_lux,
					calibrated_lux);
				error_count++;
			end else begin
				want = expected_lux.pop_front();
				if (raw_lux !== want.raw) begin
					$display("%0t raw_lux expected %0d actual %0d", $realtime, want.raw,
						raw_lux);
					error_count++;
				end
				if (calibrated_lux !== want.cal) begin
					$display("%0t calibrated_lux expected %0d actual %0d", $realtime,
						want.cal, calibrated_lux);
					error_count++;
				end
			end
		end
	end

	// wait until every pair is sent and every result has come, then the pipeline drains
	task automatic drain_pipeline();
		while (pending_pairs.size() != 0 || start || expected_lux.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		// mirror the register in the predictor, dropping unknown indexes
		if (idx == REG_GAIN_HIGH)
			gain_hi_q = val[0];
		else if (idx == REG_INTEG_SEL)
			integ_q = val;
		else if (idx == REG_PACKAGE_SEL)
			pkg_q = val[0];
	endtask

	task automatic apply_setting(logic g, logic [1:0] it, logic pk);
		write_reg(REG_GAIN_HIGH, {1'b0, g});
		write_reg(REG_INTEG_SEL, it);
		write_reg(REG_PACKAGE_SEL, {1'b0, pk});
	endtask

	function automatic count_pair_t random_pair();
		count_pair_t p;
		int sel;
		sel = $urandom_range(9);
		p.bb = COUNT_W'($urandom);
		if (sel < 2)
			p.bb = COUNT_W'($urandom_range(255));
		// infrared as a fraction of broadband to spread over every segment
		if (sel < 7)
			p.ir = COUNT_W'((32'(p.bb) * $urandom_range(1400)) / 1000);
		else
			p.ir = COUNT_W'($urandom);
		return p;
	endfunction

	initial begin
		count_pair_t d[$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, zero broadband, each segment, ratio past the last knee
		d = '{'{16'h0000, 16'h0000}, '{16'hffff, 16'hffff}, '{16'hffff, 16'h0000},
			'{16'h0000, 16'hffff}, '{16'd1000, 16'd100}, '{16'd1000, 16'd200},
			'{16'd1000, 16'd300}, '{16'd1000, 16'd450}, '{16'd1000, 16'd560},
			'{16'd1000, 16'd700}, '{16'd1000, 16'd1000}, '{16'd1000, 16'd1400},
			'{16'd1, 16'd0}, '{16'd40, 16'd5}, '{16'h5555, 16'haaaa}, '{16'haaaa, 16'h5555}};
		foreach (d[i]) pending_pairs.push_back(d[i]);
		drain_pipeline();
		apply_setting(1'b1, 2'd2, 1'b1);
		foreach (d[i]) pending_pairs.push_back(d[i]);
		drain_pipeline();
		// an unknown index is dropped
		write_reg(2'd3, 2'd3);
		// integration select 3 behaves like 2
		apply_setting(1'b1, 2'd3, 1'b0);
		for (int i = 0; i < 8; i++) pending_pairs.push_back(d[i]);
		drain_pipeline();
		// random phases across settings
		for (int ph = 0; ph < 12; ph++) begin
			apply_setting(1'($urandom_range(1)), 2'($urandom_range(3)),
				1'($urandom_range(1)));
			idle_enable = (ph != 5);
			for (int i = 0; i < 85; i++) begin
				pending_pairs.push_back(random_pair());
				if (i == 40) begin
					// hold off until the pipeline is empty
					while (pending_pairs.size() != 0 || start || expected_lux.size() != 0)
						@(posedge clk);
				end
			end
			drain_pipeline();
		end
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire
